@@ hw/rtl/gss_pkg.sv @@
// Shared types and constants of the grid step sequencer position core.
package gss_pkg;

  localparam int STEPS       = 16;
  localparam int CHANNELS    = 4;
  localparam int CH_SLOTS    = 4;
  localparam int TABLE_DEPTH = STEPS * CH_SLOTS;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int RAND_TRIES  = 32;

  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [15:0] LFSR_SEED  = 16'h0001;

  localparam logic [1:0] FUNC_GATE  = 2'd0;
  localparam logic [1:0] FUNC_KNOB  = 2'd1;
  localparam logic [1:0] FUNC_MODE  = 2'd2;
  localparam logic [1:0] FUNC_WRITE = 2'd3;

  typedef enum logic [1:0] {
    MODE_HOLD  = 2'd0,
    MODE_PLAIN = 2'd1,
    MODE_SHIFT = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  gate_bits;
    logic [1:0]  offset_x;
    logic [1:0]  offset_y;
    logic [3:0]  offset_z;
    logic [1:0]  mode_sel;
    logic [3:0]  write_step;
    logic [1:0]  write_channel;
    logic [15:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  step_index;
    logic        trigger;
    logic [15:0] cv_a;
    logic [15:0] cv_b;
    logic [15:0] cv_c;
    logic [15:0] cv_d;
  } res_t;

endpackage

@@ hw/rtl/grid_step_sequencer_position.sv @@
// Top level of the grid step sequencer position core.
//
// Usage: one command item enters on the cmd channel (cmd_valid, cmd_stall,
// cmd) and exactly one result item leaves on the res channel (res_valid,
// res_stall, res). A command is a gate event, a knob reading, a mode select
// or a table write, chosen by its func field. The result gives the shown
// step, a trigger flag when that step changed, and the four stored channel
// values of the step.
// The block works on one item at a time and holds cmd_stall high while busy.
// An item passes through the states EXEC, STEP, READ, LAST and FIN before the
// result register loads; a random gate adds the RAND state, one LFSR shift and
// compare per cycle, until a new step appears or RAND_TRIES tries are used.
// The next item is accepted in the cycle after the result loads at the earliest.
// The four channel values are read one per cycle from the single read port
// of the table RAM, which sets most of the latency.
// The result register lets the next command be accepted while a result still
// waits; when the receiver stalls, the result holds and a finished item
// waits in its last state until the register frees.
// Reset clears positions, mode and knob filters, loads the LFSR with LFSR_SEED,
// and marks every table entry empty so that it reads as zero until written.
module grid_step_sequencer_position
  import gss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RAND, S_STEP, S_READ, S_LAST, S_FIN
  } state_t;

  typedef struct packed {
    logic [3:0] acc;
    logic [3:0] cand;
    logic       seen;
  } knob_t;

  state_t state;
  cmd_t   cmd_q;
  mode_t  mode_reg;
  logic [3:0]  main_pos;
  logic [3:0]  pause_pos;
  logic [3:0]  shown_step;
  logic        trig;
  logic [15:0] lfsr;
  logic [4:0]  tries;
  logic [3:0]  acc [3];
  logic [3:0]  cand [3];
  logic        seen [3];
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [1:0]  rd_ch;
  logic [1:0]  cap_ch;
  logic        rd_pend;
  logic        rd_vld;
  logic [15:0] cv [CH_SLOTS];

  logic [3:0]  cur_pos;
  logic [3:0]  gate_pos;
  logic [15:0] lfsr_next;
  logic [3:0]  step_calc;
  logic [3:0]  knob_val [3];
  knob_t       knob_next [3];
  logic        ram_we;
  logic [TABLE_AW-1:0] ram_waddr;
  logic [TABLE_AW-1:0] ram_raddr;
  logic [15:0] ram_rdata;
  logic        res_load;

  function automatic knob_t knob_filter(input logic [3:0] a, input logic [3:0] c,
                                        input logic s, input logic [3:0] v);
    knob_t k;
    k.acc  = a;
    k.cand = c;
    k.seen = s;
    if (a != v) begin
      if (c == v) begin
        if (s) begin
          k.acc = v;
        end else begin
          k.seen = 1'b1;
        end
      end else begin
        k.cand = v;
        k.seen = 1'b0;
      end
    end
    return k;
  endfunction

  always_comb begin
    logic [3:0] p;
    logic [1:0] col;
    logic [1:0] row;
    cur_pos = (mode_reg == MODE_SHIFT) ? main_pos : pause_pos;
    p = cur_pos;
    if (cmd_q.gate_bits[0]) p = p + 4'd1;
    if (cmd_q.gate_bits[1]) p = {p[3:2], p[1:0] + 2'd1};
    if (cmd_q.gate_bits[2]) p = {p[3:2] + 2'd1, p[1:0]};
    if (cmd_q.gate_bits[3]) p = 4'd0;
    gate_pos = p;

    lfsr_next = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_TAPS : 16'd0);

    col = main_pos[1:0] + acc[0][1:0];
    row = main_pos[3:2] + acc[1][1:0];
    step_calc = (mode_reg == MODE_SHIFT) ? ({row, col} + acc[2]) : main_pos;

    knob_val[0] = {2'b00, cmd_q.offset_x};
    knob_val[1] = {2'b00, cmd_q.offset_y};
    knob_val[2] = cmd_q.offset_z;
    for (int k = 0; k < 3; k++) begin
      knob_next[k] = knob_filter(acc[k], cand[k], seen[k], knob_val[k]);
    end
  end

  assign cmd_stall = (state != S_IDLE);
  assign ram_we    = (state == S_EXEC) && (cmd_q.func == FUNC_WRITE) &&
                     ({1'b0, cmd_q.write_channel} < 3'(CHANNELS));
  assign ram_waddr = {cmd_q.write_step, cmd_q.write_channel};
  assign ram_raddr = {shown_step, rd_ch};
  assign res_load  = (state == S_FIN) && (!res_valid || !res_stall);

  gss_ram #(
    .WIDTH(16),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd_q.write_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mode_reg    <= MODE_HOLD;
      main_pos    <= '0;
      pause_pos   <= '0;
      shown_step  <= '0;
      trig        <= 1'b0;
      lfsr        <= LFSR_SEED;
      tries       <= '0;
      entry_valid <= '0;
      rd_ch       <= '0;
      cap_ch      <= '0;
      rd_pend     <= 1'b0;
      rd_vld      <= 1'b0;
      res_valid   <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        acc[k]  <= '0;
        cand[k] <= '0;
        seen[k] <= 1'b0;
      end
    end else begin
      rd_pend <= 1'b0;
      if (rd_pend) begin
        cv[cap_ch] <= (rd_vld && ({1'b0, cap_ch} < 3'(CHANNELS))) ? ram_rdata : '0;
      end
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_STEP;
          tries <= '0;
          unique case (cmd_q.func)
            FUNC_GATE: begin
              if (mode_reg == MODE_SHIFT) begin
                main_pos <= gate_pos;
              end else begin
                pause_pos <= gate_pos;
              end
              if (cmd_q.gate_bits[4]) begin
                state <= S_RAND;
              end
            end
            FUNC_KNOB: begin
              for (int k = 0; k < 3; k++) begin
                acc[k]  <= knob_next[k].acc;
                cand[k] <= knob_next[k].cand;
                seen[k] <= knob_next[k].seen;
              end
            end
            FUNC_MODE: begin
              if ((cmd_q.mode_sel == MODE_HOLD || cmd_q.mode_sel == MODE_PLAIN ||
                   cmd_q.mode_sel == MODE_SHIFT) && cmd_q.mode_sel != mode_reg) begin
                if (cmd_q.mode_sel == MODE_HOLD) begin
                  pause_pos <= main_pos;
                end else if (mode_reg == MODE_HOLD) begin
                  main_pos <= pause_pos;
                end
                mode_reg <= mode_t'(cmd_q.mode_sel);
              end
            end
            FUNC_WRITE: begin
              if (ram_we) begin
                entry_valid[ram_waddr] <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_RAND: begin
          lfsr  <= lfsr_next;
          tries <= tries + 5'd1;
          if (lfsr_next[3:0] != cur_pos) begin
            if (mode_reg == MODE_SHIFT) begin
              main_pos <= lfsr_next[3:0];
            end else begin
              pause_pos <= lfsr_next[3:0];
            end
            state <= S_STEP;
          end else if (tries == 5'(RAND_TRIES - 1)) begin
            if (mode_reg == MODE_SHIFT) begin
              main_pos <= cur_pos + 4'd1;
            end else begin
              pause_pos <= cur_pos + 4'd1;
            end
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (cmd_q.func != FUNC_WRITE) begin
            trig       <= (step_calc != shown_step);
            shown_step <= step_calc;
          end else begin
            trig <= 1'b0;
          end
          rd_ch <= '0;
          state <= S_READ;
        end
        S_READ: begin
          rd_pend <= 1'b1;
          rd_vld  <= entry_valid[ram_raddr];
          cap_ch  <= rd_ch;
          rd_ch   <= rd_ch + 2'd1;
          if (rd_ch == 2'(CH_SLOTS - 1)) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (res_load) begin
            res_valid      <= 1'b1;
            res.step_index <= shown_step;
            res.trigger    <= trig;
            res.cv_a       <= cv[0];
            res.cv_b       <= cv[1];
            res.cv_c       <= cv[2];
            res.cv_d       <= cv[3];
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/gss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/gss_checker.sv @@
// Port-level checker for the grid step sequencer position core, with its bind.
module gss_checker
  import gss_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_stall,
  input cmd_t cmd,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  logic [3:0] last_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_step <= '0;
    end else if (res_valid && !res_stall) begin
      last_step <= res.step_index;
    end
  end

  // A command occupies the block, so the next cycle never accepts another.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted while a command was in progress");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !res_valid && !cmd_stall)
    else $error("block not idle after reset");

  // The trigger flag must agree with the step shown by the previous result.
  a_no_trigger_same: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !res.trigger |-> res.step_index == last_step)
    else $error("step changed without trigger");

  a_trigger_moves: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && res.trigger |-> res.step_index != last_step)
    else $error("trigger raised without a step change");

endmodule

bind grid_step_sequencer_position gss_checker u_gss_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
